// ===== hw/rtl/orbit_camera_view_basis_top_assert.svh =====
// Assertion macros for the orbit camera view basis block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef ORBIT_CAMERA_VIEW_BASIS_TOP_ASSERT_SVH
`define ORBIT_CAMERA_VIEW_BASIS_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define OCVB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// condition holds in the cycle after the trigger
`define OCVB_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/ocvb_pkg.sv =====
// Package for the orbit camera view basis block: word types, constants,
// CORDIC arctangent table and saturation helper. No dependencies.
package ocvb_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 20;

    localparam longint PI_Q30   = 64'd3373259426;
    localparam longint GAIN_Q30 = 64'd652032874;

    typedef enum logic [2:0] {
        OP_PITCH     = 3'd0,
        OP_YAW       = 3'd1,
        OP_RADIUS    = 3'd2,
        OP_PAN_RIGHT = 3'd3,
        OP_PAN_UP    = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] amount;
    } cmd_word_t;

    typedef struct packed {
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
        logic signed [31:0] right_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] eye_x;
        logic signed [31:0] eye_y;
        logic signed [31:0] eye_z;
    } view_word_t;

    // atan(2^-i) in Q2.30
    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:    r = 36'sd843314857;
            5'd1:    r = 36'sd497837829;
            5'd2:    r = 36'sd263043837;
            5'd3:    r = 36'sd133525159;
            5'd4:    r = 36'sd67021687;
            5'd5:    r = 36'sd33543516;
            5'd6:    r = 36'sd16775851;
            5'd7:    r = 36'sd8388437;
            5'd8:    r = 36'sd4194283;
            5'd9:    r = 36'sd2097149;
            5'd10:   r = 36'sd1048576;
            5'd11:   r = 36'sd524288;
            5'd12:   r = 36'sd262144;
            5'd13:   r = 36'sd131072;
            5'd14:   r = 36'sd65536;
            5'd15:   r = 36'sd32768;
            5'd16:   r = 36'sd16384;
            5'd17:   r = 36'sd8192;
            5'd18:   r = 36'sd4096;
            5'd19:   r = 36'sd2048;
            5'd20:   r = 36'sd1024;
            5'd21:   r = 36'sd512;
            5'd22:   r = 36'sd256;
            5'd23:   r = 36'sd128;
            5'd24:   r = 36'sd64;
            5'd25:   r = 36'sd32;
            5'd26:   r = 36'sd16;
            5'd27:   r = 36'sd8;
            5'd28:   r = 36'sd4;
            default: r = 36'sd2;
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] r;
        if (v > 70'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -70'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/orbit_camera_view_basis_top.sv =====
// Orbit camera view basis: applies one pitch, yaw, radius or pan adjustment per
// command word and returns the right, up and view direction vectors and eye position.
// Uses ocvb_pkg and orbit_camera_view_basis_top_assert.svh.
//
// One command word at a time; the time per word is set by the shared CORDIC stage,
// which runs once for pitch and once for yaw, and the shared 34x34 multiplier
// (7 products, 11 for a pan word), which also does the reciprocal multiply that
// wraps yaw. cmd_stall is high while a word is in work; a finished view word waits
// in the output register, and while view_stall holds the previous view word the
// next one waits in S_OUT.
module orbit_camera_view_basis_top #(
    parameter int FRAC_BITS    = ocvb_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ocvb_pkg::CORDIC_STEPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_stall,
    input  ocvb_pkg::cmd_word_t   cmd,
    output logic                  view_valid,
    input  logic                  view_stall,
    output ocvb_pkg::view_word_t  view
);
    import ocvb_pkg::*;

    localparam int     NSTEP   = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
    localparam int     SH      = 30 - FRAC_BITS;
    localparam longint PI_L    = (PI_Q30 + (64'd1 << (SH - 1))) / (64'd1 << SH);
    localparam longint BOUND_L = ((PI_Q30 * 89 + 90) / 180 + (64'd1 << (SH - 1)))
                                 / (64'd1 << SH);
    localparam longint RMIN_L  = ((64'd1 << FRAC_BITS) + 5) / 10;
    // floor(m / 2pi) = (m * RECIP) >> YK, exact for m < 2^32
    localparam int     YK      = 32 + $clog2(2 * PI_L);
    localparam longint RECIP_L = ((64'd1 << YK) + 2 * PI_L - 1) / (2 * PI_L);

    localparam logic signed [33:0] PI_W    = 34'(PI_L);
    localparam logic signed [33:0] TWO_PI  = 34'(2 * PI_L);
    localparam logic signed [33:0] BOUND_W = 34'(BOUND_L);
    localparam logic signed [33:0] RMIN_W  = 34'(RMIN_L);
    localparam logic signed [33:0] RECIP_W = 34'(RECIP_L);
    localparam logic signed [35:0] PIQ     = 36'(PI_Q30);
    localparam logic signed [35:0] HALFPIQ = 36'(PI_Q30 / 2);
    localparam logic signed [33:0] GAIN_W  = 34'(GAIN_Q30);
    localparam logic [4:0]         LAST_IT = 5'(NSTEP - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_UPD  = 8'b0000_0010,
        S_YMOD = 8'b0000_0100,
        S_CSET = 8'b0000_1000,
        S_CORD = 8'b0001_0000,
        S_MUL  = 8'b0010_0000,
        S_ACC  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic signed [31:0] pitch_reg, pitch_next;
    logic signed [31:0] yaw_reg, yaw_next;
    logic signed [31:0] radius_reg, radius_next;
    logic signed [31:0] target_reg [3];
    logic signed [31:0] target_next [3];

    logic [2:0]         op_reg, op_next;
    logic signed [31:0] amt_reg, amt_next;
    logic [33:0]        mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic [4:0]         it_reg, it_next;
    logic signed [33:0] x_reg, x_next, y_reg, y_next;
    logic signed [35:0] z_reg, z_next;
    logic signed [33:0] sp_reg, sp_next, cp_reg, cp_next;
    logic signed [33:0] sy_reg, sy_next, cy_reg, cy_next;
    logic signed [33:0] b3_reg, b3_next, b5_reg, b5_next;
    logic signed [33:0] b6_reg, b6_next, b8_reg, b8_next;
    logic signed [31:0] step_reg, step_next;
    logic signed [31:0] eye_reg [3];
    logic signed [31:0] eye_next [3];
    logic [3:0]         idx_reg, idx_next;
    logic signed [67:0] prod_reg, prod_next;
    view_word_t         view_reg, view_next;

    logic signed [33:0] mul_a, mul_b;
    logic signed [33:0] sum34, rsum34, yaw_v;
    logic [33:0]        rem_new, yaw_r;
    logic signed [35:0] ang_z;
    logic signed [33:0] dx, dy, xn, yn;
    logic signed [37:0] r30;
    logic signed [67:0] rf;
    logic               is_pan;

    function automatic logic signed [31:0] out_fx(input logic signed [33:0] b);
        logic signed [34:0] t;
        t = (35'(b) + (35'sd1 <<< (SH - 1))) >>> SH;
        return sat32(70'(t));
    endfunction

    assign is_pan = (op_reg == OP_PAN_RIGHT) || (op_reg == OP_PAN_UP);

    always_comb
    begin
        case (idx_reg)
            4'd0:    begin mul_a = -sp_reg; mul_b = sy_reg; end
            4'd1:    begin mul_a = sp_reg;  mul_b = cy_reg; end
            4'd2:    begin mul_a = -cp_reg; mul_b = sy_reg; end
            4'd3:    begin mul_a = cp_reg;  mul_b = cy_reg; end
            4'd4:    begin mul_a = 34'(radius_reg); mul_b = 34'(amt_reg); end
            4'd5:    begin mul_a = 34'(step_reg);
                         mul_b = (op_reg == OP_PAN_RIGHT) ? cy_reg : b3_reg; end
            4'd6:    begin mul_a = 34'(step_reg);
                         mul_b = (op_reg == OP_PAN_RIGHT) ? 34'sd0 : cp_reg; end
            4'd7:    begin mul_a = 34'(step_reg);
                         mul_b = (op_reg == OP_PAN_RIGHT) ? sy_reg : b5_reg; end
            4'd8:    begin mul_a = 34'(radius_reg); mul_b = b6_reg; end
            4'd9:    begin mul_a = 34'(radius_reg); mul_b = -sp_reg; end
            4'd10:   begin mul_a = 34'(radius_reg); mul_b = b8_reg; end
            4'd11:   begin mul_a = $signed(mag_reg); mul_b = RECIP_W; end
            4'd12:   begin mul_a = 34'(prod_reg >>> YK); mul_b = TWO_PI; end
            default: begin mul_a = 34'sd0; mul_b = 34'sd0; end
        endcase
    end

    always_comb
    begin
        sum34   = 34'(pitch_reg) + 34'(amt_reg);
        rsum34  = 34'(radius_reg) + 34'(amt_reg);
        yaw_v   = 34'(yaw_reg) + 34'(amt_reg) + PI_W;
        rem_new = mag_reg - prod_reg[33:0];
        yaw_r   = (neg_reg && rem_new != 34'd0) ? TWO_PI - rem_new : rem_new;
        ang_z   = (phase_reg ? 36'(yaw_reg) : 36'(pitch_reg)) <<< SH;
        dx      = y_reg >>> it_reg;
        dy      = x_reg >>> it_reg;
        xn      = (z_reg >= 36'sd0) ? x_reg - dx : x_reg + dx;
        yn      = (z_reg >= 36'sd0) ? y_reg + dy : y_reg - dy;
        r30     = 38'((prod_reg + (68'sd1 <<< 29)) >>> 30);
        rf      = (prod_reg + (68'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && view_stall;
        pitch_next     = pitch_reg;
        yaw_next       = yaw_reg;
        radius_next    = radius_reg;
        target_next    = target_reg;
        op_next        = op_reg;
        amt_next       = amt_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        it_next        = it_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        sp_next        = sp_reg;
        cp_next        = cp_reg;
        sy_next        = sy_reg;
        cy_next        = cy_reg;
        b3_next        = b3_reg;
        b5_next        = b5_reg;
        b6_next        = b6_reg;
        b8_next        = b8_reg;
        step_next      = step_reg;
        eye_next       = eye_reg;
        idx_next       = idx_reg;
        prod_next      = prod_reg;
        view_next      = view_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd.opcode;
                    amt_next   = cmd.amount;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                phase_next = 1'b0;
                state_next = S_CSET;
                if (op_reg == OP_PITCH)
                begin
                    if (sum34 > BOUND_W)
                        pitch_next = BOUND_W[31:0];
                    else if (sum34 < -BOUND_W)
                        pitch_next = 32'(-BOUND_W);
                    else
                        pitch_next = sum34[31:0];
                end
                else if (op_reg == OP_RADIUS)
                begin
                    if (rsum34 < RMIN_W)
                        radius_next = RMIN_W[31:0];
                    else
                        radius_next = sat32(70'(rsum34));
                end
                else if (op_reg == OP_YAW)
                begin
                    neg_next   = yaw_v[33];
                    mag_next   = yaw_v[33] ? 34'(-yaw_v) : 34'(yaw_v);
                    cnt_next   = 6'd0;
                    idx_next   = 4'd11;
                    state_next = S_YMOD;
                end
            end
            S_YMOD:
            begin
                // quotient by reciprocal, then remainder
                if (cnt_reg == 6'd0)
                begin
                    prod_next = mul_a * mul_b;
                    idx_next  = 4'd12;
                    cnt_next  = 6'd1;
                end
                else if (cnt_reg == 6'd1)
                begin
                    prod_next = mul_a * mul_b;
                    cnt_next  = 6'd2;
                end
                else
                begin
                    yaw_next   = 32'(34'(yaw_r) - PI_W);
                    state_next = S_CSET;
                end
            end
            S_CSET:
            begin
                x_next  = GAIN_W;
                y_next  = 34'sd0;
                it_next = 5'd0;
                if (ang_z > HALFPIQ)
                begin
                    z_next   = ang_z - PIQ;
                    neg_next = 1'b1;
                end
                else if (ang_z < -HALFPIQ)
                begin
                    z_next   = ang_z + PIQ;
                    neg_next = 1'b1;
                end
                else
                begin
                    z_next   = ang_z;
                    neg_next = 1'b0;
                end
                state_next = S_CORD;
            end
            S_CORD:
            begin
                x_next  = xn;
                y_next  = yn;
                z_next  = (z_reg >= 36'sd0) ? z_reg - atan_q30(it_reg)
                                            : z_reg + atan_q30(it_reg);
                it_next = it_reg + 5'd1;
                if (it_reg == LAST_IT)
                begin
                    if (phase_reg)
                    begin
                        sy_next    = neg_reg ? -yn : yn;
                        cy_next    = neg_reg ? -xn : xn;
                        idx_next   = 4'd0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        sp_next    = neg_reg ? -yn : yn;
                        cp_next    = neg_reg ? -xn : xn;
                        phase_next = 1'b1;
                        state_next = S_CSET;
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_MUL;
                idx_next   = idx_reg + 4'd1;
                case (idx_reg)
                    4'd0: b3_next = r30[33:0];
                    4'd1: b5_next = r30[33:0];
                    4'd2: b6_next = r30[33:0];
                    4'd3:
                    begin
                        b8_next  = r30[33:0];
                        idx_next = is_pan ? 4'd4 : 4'd8;
                    end
                    4'd4: step_next = sat32(70'(rf));
                    4'd5: target_next[0] = sat32(70'(target_reg[0]) + 70'(r30));
                    4'd6: target_next[1] = sat32(70'(target_reg[1]) + 70'(r30));
                    4'd7: target_next[2] = sat32(70'(target_reg[2]) + 70'(r30));
                    4'd8: eye_next[0] = sat32(70'(target_reg[0]) + 70'(r30));
                    4'd9: eye_next[1] = sat32(70'(target_reg[1]) + 70'(r30));
                    default:
                    begin
                        eye_next[2] = sat32(70'(target_reg[2]) + 70'(r30));
                        state_next  = S_OUT;
                    end
                endcase
            end
            S_OUT:
            begin
                if (!out_valid_reg || !view_stall)
                begin
                    view_next.right_x = out_fx(cy_reg);
                    view_next.right_y = 32'sd0;
                    view_next.right_z = out_fx(sy_reg);
                    view_next.up_x    = out_fx(b3_reg);
                    view_next.up_y    = out_fx(cp_reg);
                    view_next.up_z    = out_fx(b5_reg);
                    view_next.dir_x   = out_fx(b6_reg);
                    view_next.dir_y   = out_fx(-sp_reg);
                    view_next.dir_z   = out_fx(b8_reg);
                    view_next.eye_x   = eye_reg[0];
                    view_next.eye_y   = eye_reg[1];
                    view_next.eye_z   = eye_reg[2];
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            pitch_reg     <= '0;
            yaw_reg       <= '0;
            radius_reg    <= 32'sd1 <<< FRAC_BITS;
            target_reg    <= '{default: '0};
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pitch_reg     <= pitch_next;
            yaw_reg       <= yaw_next;
            radius_reg    <= radius_next;
            target_reg    <= target_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        amt_reg   <= amt_next;
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        cnt_reg   <= cnt_next;
        phase_reg <= phase_next;
        it_reg    <= it_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        sp_reg    <= sp_next;
        cp_reg    <= cp_next;
        sy_reg    <= sy_next;
        cy_reg    <= cy_next;
        b3_reg    <= b3_next;
        b5_reg    <= b5_next;
        b6_reg    <= b6_next;
        b8_reg    <= b8_next;
        step_reg  <= step_next;
        eye_reg   <= eye_next;
        idx_reg   <= idx_next;
        prod_reg  <= prod_next;
        view_reg  <= view_next;
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign view_valid = out_valid_reg;
    assign view       = view_reg;

`include "orbit_camera_view_basis_top_assert.svh"

    `OCVB_ASSERT_ALWAYS(a_pitch_bound,
        (34'(pitch_reg) <= BOUND_W) && (34'(pitch_reg) >= -BOUND_W), "pitch out of range")
    `OCVB_ASSERT_ALWAYS(a_yaw_wrap,
        (34'(yaw_reg) >= -PI_W) && (34'(yaw_reg) < PI_W), "yaw not wrapped")
    `OCVB_ASSERT_ALWAYS(a_radius_min, 34'(radius_reg) >= RMIN_W, "radius below minimum")
    `OCVB_ASSERT_NEXT(a_accept_start, cmd_valid && !cmd_stall, state_reg == S_UPD,
        "accepted word did not start update")

endmodule
